FILE: rtl/core/erasc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// erasc_pkg
// Shared types and constants of the event ring anomaly scorer.
// ----------------------------------------------------------------------------
package erasc_pkg;

    localparam int RING_DEPTH = 4096;
    localparam int PTR_W      = $clog2(RING_DEPTH);
    localparam int FILL_W     = $clog2(RING_DEPTH + 1);

    // fixed field widths of the channels and registers
    localparam int ACT_W   = 2;
    localparam int KIND_W  = 4;
    localparam int PID_W   = 32;
    localparam int TOT_W   = 32;
    localparam int CFG_W   = 13;
    localparam int LVL_W   = 2;
    localparam int BUF_W   = 13;
    localparam int CIDX_W  = 2;
    localparam int WORD_W  = KIND_W + PID_W;
    localparam int CMP_W   = (FILL_W > CFG_W) ? FILL_W : CFG_W;

    // action codes
    localparam logic [ACT_W-1:0] ACT_LOG   = 2'd0;
    localparam logic [ACT_W-1:0] ACT_QUERY = 2'd1;
    localparam logic [ACT_W-1:0] ACT_CLEAR = 2'd2;

    // event kind codes that matter
    localparam logic [KIND_W-1:0] KIND_DELETE   = 4'd6;
    localparam logic [KIND_W-1:0] KIND_CONNECT  = 4'd7;
    localparam logic [KIND_W-1:0] KIND_SYSCALL  = 4'd10;
    localparam logic [KIND_W-1:0] KIND_ESCALATE = 4'd11;

    // configuration register indexes
    localparam logic [CIDX_W-1:0] CFG_LOG_ENABLE    = 2'd0;
    localparam logic [CIDX_W-1:0] CFG_SCAN_WINDOW   = 2'd1;
    localparam logic [CIDX_W-1:0] CFG_DELETE_LIMIT  = 2'd2;
    localparam logic [CIDX_W-1:0] CFG_CONNECT_LIMIT = 2'd3;

    // status and level codes
    localparam logic STAT_DONE     = 1'b0;
    localparam logic STAT_REJECTED = 1'b1;
    localparam logic [LVL_W-1:0] LVL_NORMAL   = 2'd0;
    localparam logic [LVL_W-1:0] LVL_WARNING  = 2'd1;
    localparam logic [LVL_W-1:0] LVL_CRITICAL = 2'd2;

    typedef enum logic [1:0] {
        OP_LOG,
        OP_QUERY,
        OP_CLEAR,
        OP_NOP
    } t_op;

    typedef struct packed {
        t_op               op;
        logic              suspicious;
        logic [KIND_W-1:0] kind;
        logic [PID_W-1:0]  pid;
    } t_cmd;

    typedef struct packed {
        logic             log_enable;
        logic [CFG_W-1:0] scan_window;
        logic [CFG_W-1:0] delete_limit;
        logic [CFG_W-1:0] connect_limit;
    } t_cfg;

endpackage

FILE: rtl/core/erasc_in_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// erasc_in_if
// Request channel: action, event kind and process id.
// ----------------------------------------------------------------------------
interface erasc_in_if;
    import erasc_pkg::*;

    logic              valid;
    logic              ready;
    logic [ACT_W-1:0]  action;
    logic [KIND_W-1:0] event_kind;
    logic [PID_W-1:0]  event_pid;

    modport source (output valid, action, event_kind, event_pid, input ready);
    modport sink   (input valid, action, event_kind, event_pid, output ready);
endinterface

FILE: rtl/core/erasc_out_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// erasc_out_if
// Result channel: status, level and running counters.
// ----------------------------------------------------------------------------
interface erasc_out_if;
    import erasc_pkg::*;

    logic             valid;
    logic             ready;
    logic             status;
    logic [LVL_W-1:0] anomaly_level;
    logic [TOT_W-1:0] total_logged;
    logic [TOT_W-1:0] suspicious_total;
    logic [BUF_W-1:0] buffered_count;

    modport source (output valid, status, anomaly_level, total_logged, suspicious_total,
                    buffered_count, input ready);
    modport sink   (input valid, status, anomaly_level, total_logged, suspicious_total,
                    buffered_count, output ready);
endinterface

FILE: rtl/core/erasc_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// erasc_front
// Accepts request transactions and decodes them into queue commands.
// ----------------------------------------------------------------------------
module erasc_front (
    erasc_in_if.sink           i_evt,
    input  logic               i_full,
    output logic               o_push,
    output erasc_pkg::t_cmd    o_cmd
);
    import erasc_pkg::*;

    t_op op;

    always_comb begin
        unique case (i_evt.action)
            ACT_LOG:   op = OP_LOG;
            ACT_QUERY: op = OP_QUERY;
            ACT_CLEAR: op = OP_CLEAR;
            default:   op = OP_NOP;
        endcase
    end

    assign i_evt.ready      = !i_full;
    assign o_push           = i_evt.valid && !i_full;
    assign o_cmd.op         = op;
    assign o_cmd.suspicious = (i_evt.event_kind == KIND_DELETE)
                           || (i_evt.event_kind == KIND_SYSCALL)
                           || (i_evt.event_kind == KIND_ESCALATE);
    assign o_cmd.kind       = i_evt.event_kind;
    assign o_cmd.pid        = i_evt.event_pid;

endmodule

FILE: rtl/core/erasc_cmd_fifo.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// erasc_cmd_fifo
// Two-entry command queue between the front and back parts.
// ----------------------------------------------------------------------------
module erasc_cmd_fifo (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_push,
    input  erasc_pkg::t_cmd    i_cmd,
    input  logic               i_pop,
    output erasc_pkg::t_cmd    o_cmd,
    output logic               o_full,
    output logic               o_empty
);
    import erasc_pkg::*;

    t_cmd       r_slot [2];
    logic       r_wr_ptr;
    logic       r_rd_ptr;
    logic [1:0] r_count;

    assign o_full  = (r_count == 2'd2);
    assign o_empty = (r_count == 2'd0);
    assign o_cmd   = r_slot[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_slot[r_wr_ptr] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= !r_wr_ptr;
            end
            if (i_pop) begin
                r_rd_ptr <= !r_rd_ptr;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 2'd1;
            end else if (i_pop && !i_push) begin
                r_count <= r_count - 2'd1;
            end
        end
    end

endmodule

FILE: rtl/core/erasc_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// erasc_back
// Executes commands: ring writes, windowed scan with grading, clear,
// and holds the result register.
// ----------------------------------------------------------------------------
module erasc_back (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  erasc_pkg::t_cfg    i_cfg,
    input  erasc_pkg::t_cmd    i_cmd,
    input  logic               i_empty,
    output logic               o_pop,
    erasc_out_if.source        o_res
);
    import erasc_pkg::*;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DRAIN,
        ST_GRADE
    } t_state;

    t_state              r_state;
    logic [WORD_W-1:0]   r_mem [RING_DEPTH];
    logic [WORD_W-1:0]   r_rd_word;
    logic                r_rd_vld;
    logic [PTR_W-1:0]    r_wp;
    logic [PTR_W-1:0]    r_addr;
    logic [FILL_W-1:0]   r_fill;
    logic [FILL_W-1:0]   r_left;
    logic [FILL_W-1:0]   r_dels;
    logic [FILL_W-1:0]   r_escs;
    logic [FILL_W-1:0]   r_cons;
    logic [PID_W-1:0]    r_qpid;
    logic [TOT_W-1:0]    r_total;
    logic [TOT_W-1:0]    r_susp;
    logic                r_out_valid;
    logic                r_status;
    logic [LVL_W-1:0]    r_level;

    logic                out_free;
    logic                out_set;
    logic                pop;
    logic                log_go;
    logic [FILL_W-1:0]   scan_n;
    logic [FILL_W-1:0]   wp_ext;
    logic [FILL_W-1:0]   start_ext;
    logic [PTR_W-1:0]    wp_next;
    logic [PTR_W-1:0]    addr_next;
    logic [KIND_W-1:0]   rd_kind;
    logic                hit;
    logic                dels_over;
    logic                cons_over;
    logic                esc_seen;
    logic [LVL_W-1:0]    grade;

    assign out_free = !r_out_valid || o_res.ready;
    assign pop      = (r_state == ST_IDLE) && !i_empty
                   && ((i_cmd.op == OP_QUERY) || out_free);
    assign o_pop    = pop;
    assign log_go   = pop && (i_cmd.op == OP_LOG) && i_cfg.log_enable;
    assign out_set  = (pop && (i_cmd.op != OP_QUERY))
                   || ((r_state == ST_GRADE) && out_free);

    // window bounded by the fill level, start counted back from the write pointer
    assign scan_n    = (CMP_W'(i_cfg.scan_window) < CMP_W'(r_fill))
                     ? FILL_W'(i_cfg.scan_window) : r_fill;
    assign wp_ext    = FILL_W'(r_wp);
    assign start_ext = (wp_ext >= scan_n) ? (wp_ext - scan_n)
                     : (wp_ext + FILL_W'(RING_DEPTH) - scan_n);

    assign wp_next   = (r_wp == PTR_W'(RING_DEPTH - 1)) ? '0 : r_wp + 1'b1;
    assign addr_next = (r_addr == PTR_W'(RING_DEPTH - 1)) ? '0 : r_addr + 1'b1;

    assign rd_kind   = r_rd_word[WORD_W-1 -: KIND_W];
    assign hit       = r_rd_vld && (r_rd_word[PID_W-1:0] == r_qpid);

    assign dels_over = CMP_W'(r_dels) > CMP_W'(i_cfg.delete_limit);
    assign cons_over = CMP_W'(r_cons) > CMP_W'(i_cfg.connect_limit);
    assign esc_seen  = (r_escs != '0);

    always_comb begin
        if (esc_seen && (dels_over || cons_over)) begin
            grade = LVL_CRITICAL;
        end else if (esc_seen || dels_over || cons_over) begin
            grade = LVL_WARNING;
        end else begin
            grade = LVL_NORMAL;
        end
    end

    // ring storage, registered read port
    always_ff @(posedge i_clk) begin
        if (log_go) begin
            r_mem[r_wp] <= {i_cmd.kind, i_cmd.pid};
        end
    end

    always_ff @(posedge i_clk) begin
        r_rd_word <= r_mem[r_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_wp        <= '0;
            r_fill      <= '0;
            r_total     <= '0;
            r_susp      <= '0;
            r_rd_vld    <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (out_set) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && o_res.ready) begin
                r_out_valid <= 1'b0;
            end
            r_rd_vld <= (r_state == ST_SCAN);

            if (hit) begin
                case (rd_kind)
                    KIND_DELETE:   r_dels <= r_dels + 1'b1;
                    KIND_ESCALATE: r_escs <= r_escs + 1'b1;
                    KIND_CONNECT:  r_cons <= r_cons + 1'b1;
                    default:       ;
                endcase
            end

            unique case (r_state)
                ST_IDLE: begin
                    if (pop) begin
                        unique case (i_cmd.op)
                            OP_LOG: begin
                                r_level <= LVL_NORMAL;
                                if (i_cfg.log_enable) begin
                                    r_status <= STAT_DONE;
                                    r_wp     <= wp_next;
                                    r_total  <= r_total + 1'b1;
                                    if (r_fill < FILL_W'(RING_DEPTH)) begin
                                        r_fill <= r_fill + 1'b1;
                                    end
                                    if (i_cmd.suspicious) begin
                                        r_susp <= r_susp + 1'b1;
                                    end
                                end else begin
                                    r_status <= STAT_REJECTED;
                                end
                            end
                            OP_QUERY: begin
                                r_qpid <= i_cmd.pid;
                                r_dels <= '0;
                                r_escs <= '0;
                                r_cons <= '0;
                                r_addr <= PTR_W'(start_ext);
                                r_left <= scan_n;
                                r_state <= (scan_n == '0) ? ST_GRADE : ST_SCAN;
                            end
                            OP_CLEAR: begin
                                r_wp     <= '0;
                                r_fill   <= '0;
                                r_status <= STAT_DONE;
                                r_level  <= LVL_NORMAL;
                            end
                            default: begin
                                r_status <= STAT_DONE;
                                r_level  <= LVL_NORMAL;
                            end
                        endcase
                    end
                end
                ST_SCAN: begin
                    r_addr <= addr_next;
                    r_left <= r_left - 1'b1;
                    if (r_left == FILL_W'(1)) begin
                        r_state <= ST_DRAIN;
                    end
                end
                ST_DRAIN: begin
                    // last read word is counted at this edge
                    r_state <= ST_GRADE;
                end
                ST_GRADE: begin
                    if (out_free) begin
                        r_status <= STAT_DONE;
                        r_level  <= grade;
                        r_state  <= ST_IDLE;
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    assign o_res.valid            = r_out_valid;
    assign o_res.status           = r_status;
    assign o_res.anomaly_level    = r_level;
    assign o_res.total_logged     = r_total;
    assign o_res.suspicious_total = r_susp;
    assign o_res.buffered_count   = BUF_W'(r_fill);

endmodule

FILE: rtl/core/event_ring_anomaly_scorer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// event_ring_anomaly_scorer
// Circular event trace with per-process anomaly grading.
// ----------------------------------------------------------------------------
// Usage:
//   i_evt carries requests (log, query, clear); o_res returns exactly one
//   result transaction per request, in order, with the running counters.
//   Configuration is written through i_cfg_we / i_cfg_idx / i_cfg_data;
//   the user must write it only while no request is in flight, as the block
//   itself does not enforce this.
// Throughput:
//   log, clear and unknown actions run at one transaction per cycle while
//   o_res.ready stays high; each result is registered after the command
//   passes the command queue. A query walks the newest min(scan_window, fill)
//   ring entries through the single registered read port, one per cycle.
// Stall:
//   a waiting result holds o_res; a two-entry command queue keeps taking
//   requests until it fills, then i_evt.ready drops.
// Reset:
//   pointer, fill count and counters clear; registers return to enable 1,
//   window 100, delete limit 10, connect limit 5; ring contents are kept.
// ----------------------------------------------------------------------------
module event_ring_anomaly_scorer (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    erasc_in_if.sink                      i_evt,
    erasc_out_if.source                   o_res,
    input  logic                          i_cfg_we,
    input  logic [erasc_pkg::CIDX_W-1:0]  i_cfg_idx,
    input  logic [erasc_pkg::CFG_W-1:0]   i_cfg_data
);
    import erasc_pkg::*;

    t_cfg r_cfg;
    t_cmd push_cmd;
    t_cmd pop_cmd;
    logic push;
    logic pop;
    logic fifo_full;
    logic fifo_empty;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.log_enable    <= 1'b1;
            r_cfg.scan_window   <= CFG_W'(100);
            r_cfg.delete_limit  <= CFG_W'(10);
            r_cfg.connect_limit <= CFG_W'(5);
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_LOG_ENABLE:    r_cfg.log_enable    <= i_cfg_data[0];
                CFG_SCAN_WINDOW:   r_cfg.scan_window   <= i_cfg_data;
                CFG_DELETE_LIMIT:  r_cfg.delete_limit  <= i_cfg_data;
                CFG_CONNECT_LIMIT: r_cfg.connect_limit <= i_cfg_data;
                default:           ;
            endcase
        end
    end

    erasc_front u_front (
        .i_evt  (i_evt),
        .i_full (fifo_full),
        .o_push (push),
        .o_cmd  (push_cmd)
    );

    erasc_cmd_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_cmd   (push_cmd),
        .i_pop   (pop),
        .o_cmd   (pop_cmd),
        .o_full  (fifo_full),
        .o_empty (fifo_empty)
    );

    erasc_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (r_cfg),
        .i_cmd   (pop_cmd),
        .i_empty (fifo_empty),
        .o_pop   (pop),
        .o_res   (o_res)
    );

`ifndef ASSERT_OFF
    // an empty queue always takes a request
    a_empty_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        fifo_empty |-> i_evt.ready)
        else $error("queue empty but request channel stalled");

    // never pop an empty queue
    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        pop |-> !fifo_empty)
        else $error("pop from empty command queue");

    // a rejected log carries no grade
    a_reject_level: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res.valid && o_res.status) |-> (o_res.anomaly_level == LVL_NORMAL))
        else $error("rejected log with nonzero level");

    // ring never reports more entries than it holds
    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res.valid |-> (o_res.buffered_count <= BUF_W'(RING_DEPTH)))
        else $error("buffered count beyond ring depth");
`endif

endmodule
